### design/prle_pkg.sv
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types and constants of the PackBits run-length encoder: the command
// word passed from the front end to the back end and the literal store write.
// ----------------------------------------------------------------------------
package prle_pkg;

    localparam int LIT_CNT_W = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CNT_W   = 3;
    localparam int NPEND     = 4;

    localparam logic [1:0] CMD_RUN = 2'd0;
    localparam logic [1:0] CMD_LIT = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    localparam logic [7:0] END_BYTE = 8'd128;
    localparam logic [8:0] RUN_BASE = 9'd257;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           len;
        logic [7:0]           value;
        logic [LIT_CNT_W-1:0] cnt;
        logic                 tail;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic                 en;
        logic [LIT_CNT_W-1:0] addr;
        logic [7:0]           data;
    } t_wr;

    function automatic t_cmd mk_cmd(input logic [1:0] kind, input logic [7:0] len,
                                    input logic [7:0] value,
                                    input logic [LIT_CNT_W-1:0] cnt, input logic tail);
        t_cmd c;
        c.kind  = kind;
        c.len   = len;
        c.value = value;
        c.cnt   = cnt;
        c.tail  = tail;
        c.last  = 1'b0;
        return c;
    endfunction

endpackage

### design/prle_queue.sv
// ----------------------------------------------------------------------------
// prle_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module prle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  prle_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output prle_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);

    prle_pkg::t_cmd                   r_mem [prle_pkg::Q_DEPTH];
    logic [prle_pkg::Q_AW-1:0]        r_wp;
    logic [prle_pkg::Q_AW-1:0]        r_rp;
    logic [prle_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                             w_push;
    logic                             w_pop;

    assign o_full  = (r_cnt == prle_pkg::Q_CNT_W'(prle_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### design/prle_front.sv
// ----------------------------------------------------------------------------
// prle_front
// Accepts raw bytes, tracks the current run and literal count, writes literal
// bytes to the store and turns each item into up to three commands.
// ----------------------------------------------------------------------------
module prle_front #(
    parameter int MAX_LITERAL = 32,
    parameter int MAX_RUN     = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data,
    input  logic            i_last,
    output logic            o_push,
    output prle_pkg::t_cmd  o_cmd,
    input  logic            i_full,
    output prle_pkg::t_wr   o_wr,
    input  logic            i_lit_done
);

    logic [7:0]                       r_held_byte;
    logic                             r_held_valid;
    logic [7:0]                       r_run_len;
    logic [prle_pkg::LIT_CNT_W-1:0]   r_lit_cnt;
    logic                             r_lit_busy;
    prle_pkg::t_cmd                   r_pend   [prle_pkg::NPEND];
    logic [prle_pkg::NPEND-1:0]       r_pend_v;

    logic [7:0]                       w_hb;
    logic                             w_hv;
    logic [7:0]                       w_rl;
    logic [prle_pkg::LIT_CNT_W-1:0]   w_lc;
    logic [2:0]                       w_n;
    logic                             w_busy;
    logic                             w_wr_en;
    logic [prle_pkg::LIT_CNT_W-1:0]   w_wr_addr;
    prle_pkg::t_cmd                   w_cmd    [prle_pkg::NPEND];
    logic                             w_acc;

    assign o_ready = !r_pend_v[0] && !r_lit_busy;
    assign w_acc   = i_valid && o_ready;
    assign o_push  = r_pend_v[0];
    assign o_cmd   = r_pend[0];

    assign o_wr.en   = w_acc && w_wr_en;
    assign o_wr.addr = w_wr_addr;
    assign o_wr.data = r_held_byte;

    always_comb begin
        w_hb      = r_held_byte;
        w_hv      = r_held_valid;
        w_rl      = r_run_len;
        w_lc      = r_lit_cnt;
        w_n       = 3'd0;
        w_busy    = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_lit_cnt;
        for (int i = 0; i < prle_pkg::NPEND; i++) begin
            w_cmd[i] = '0;
        end

        if (!w_hv) begin
            w_hb = i_data;
            w_hv = 1'b1;
            w_rl = 8'd1;
        end else if (i_data == w_hb) begin
            if (w_rl <= 8'd1) begin
                if (w_lc != '0) begin
                    w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_LIT, w_rl, w_hb, w_lc,
                                                       1'b0);
                    w_n    = w_n + 3'd1;
                    w_busy = 1'b1;
                end
                w_lc = '0;
            end
            w_rl = w_rl + 8'd1;
            if ({1'b0, w_rl} >= 9'(MAX_RUN)) begin
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_RUN, w_rl, w_hb, w_lc, 1'b0);
                w_n  = w_n + 3'd1;
                w_hv = 1'b0;
                w_rl = 8'd0;
            end
        end else begin
            if (w_rl >= 8'd2) begin
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_RUN, w_rl, w_hb, w_lc, 1'b0);
                w_n = w_n + 3'd1;
            end else if ({1'b0, w_lc} + 7'd1 >= 7'(MAX_LITERAL)) begin
                // block full: held byte goes out as the tail
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_LIT, w_rl, w_hb, w_lc, 1'b1);
                w_n    = w_n + 3'd1;
                w_busy = (w_lc != '0);
                w_lc   = '0;
            end else begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_lc;
                w_lc      = w_lc + 1'b1;
            end
            w_hb = i_data;
            w_hv = 1'b1;
            w_rl = 8'd1;
        end

        if (i_last) begin
            if (w_hv && (w_rl >= 8'd2)) begin
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_RUN, w_rl, w_hb, w_lc, 1'b0);
                w_n  = w_n + 3'd1;
                w_hv = 1'b0;
            end
            if (w_hv) begin
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_LIT, w_rl, w_hb, w_lc, 1'b1);
                w_n    = w_n + 3'd1;
                w_busy = w_busy || (w_lc != '0);
            end else if (w_lc != '0) begin
                w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_LIT, w_rl, w_hb, w_lc, 1'b0);
                w_n    = w_n + 3'd1;
                w_busy = 1'b1;
            end
            w_cmd[w_n[1:0]] = prle_pkg::mk_cmd(prle_pkg::CMD_END, w_rl, w_hb, w_lc, 1'b0);
            w_n  = w_n + 3'd1;
            w_hb = 8'd0;
            w_hv = 1'b0;
            w_rl = 8'd0;
            w_lc = '0;
        end

        if (w_n != 3'd0) begin
            w_cmd[w_n[1:0] - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int i = 0; i < prle_pkg::NPEND; i++) begin
                r_pend[i] <= w_cmd[i];
            end
        end else if (r_pend_v[0] && !i_full) begin
            for (int i = 0; i < prle_pkg::NPEND - 1; i++) begin
                r_pend[i] <= r_pend[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= 8'd0;
            r_held_valid <= 1'b0;
            r_run_len    <= 8'd0;
            r_lit_cnt    <= '0;
            r_lit_busy   <= 1'b0;
            r_pend_v     <= '0;
        end else begin
            if (w_acc) begin
                r_held_byte  <= w_hb;
                r_held_valid <= w_hv;
                r_run_len    <= w_rl;
                r_lit_cnt    <= w_lc;
                r_lit_busy   <= w_busy;
                for (int i = 0; i < prle_pkg::NPEND; i++) begin
                    r_pend_v[i] <= (3'(i) < w_n);
                end
            end else begin
                if (i_lit_done) begin
                    r_lit_busy <= 1'b0;
                end
                if (r_pend_v[0] && !i_full) begin
                    r_pend_v <= {1'b0, r_pend_v[prle_pkg::NPEND-1:1]};
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_held_has_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_run_len != 8'd0))
        else $error("held byte without run length");

    a_lit_below_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ({1'b0, r_lit_cnt} < 7'(MAX_LITERAL)))
        else $error("literal count at cap on accept");
`endif

endmodule

### design/prle_back.sv
// ----------------------------------------------------------------------------
// prle_back
// Executes queued commands: run pairs, literal blocks replayed from the
// literal store, and the end-of-data byte, one output byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module prle_back #(
    parameter int MAX_LITERAL = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  prle_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    input  prle_pkg::t_wr   i_wr,
    output logic            o_lit_done,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    output logic [7:0]      o_data,
    output logic            o_last,
    output logic            o_user
);

    localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LIT  = 2'd2;
    localparam logic [1:0] S_TAIL = 2'd3;

    logic [7:0]                       r_store [MAX_LITERAL];
    logic [7:0]                       r_rd_data;
    logic [1:0]                       r_state;
    logic [7:0]                       r_val;
    logic [prle_pkg::LIT_CNT_W-1:0]   r_cnt;
    logic [prle_pkg::LIT_CNT_W-1:0]   r_idx;
    logic                             r_tail;
    logic                             r_last;
    logic                             r_out_valid;
    logic [7:0]                       r_out_byte;
    logic                             r_out_last;
    logic                             r_out_user;

    logic                             w_free;
    logic                             w_rd_en;
    logic [prle_pkg::LIT_CNT_W-1:0]   w_rd_addr;
    logic                             w_lit_end;

    assign o_m_valid = r_out_valid;
    assign o_data    = r_out_byte;
    assign o_last    = r_out_last;
    assign o_user    = r_out_user;

    assign w_free     = !r_out_valid || i_m_ready;
    assign o_pop      = (r_state == S_IDLE) && i_valid && w_free;
    assign w_lit_end  = (r_idx == r_cnt);
    assign o_lit_done = (r_state == S_LIT) && w_free && w_lit_end;

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (o_pop && (i_cmd.kind == prle_pkg::CMD_LIT) && (i_cmd.cnt != '0)) begin
            w_rd_en = 1'b1;
        end else if ((r_state == S_LIT) && w_free && !w_lit_end) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[w_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_pop || ((r_state != S_IDLE) && w_free)
                           || (r_out_valid && !i_m_ready);
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_val       <= i_cmd.value;
                        r_cnt       <= i_cmd.cnt;
                        r_tail      <= i_cmd.tail;
                        r_last      <= i_cmd.last;
                        r_idx       <= prle_pkg::LIT_CNT_W'(1);
                        case (i_cmd.kind)
                            prle_pkg::CMD_RUN: begin
                                r_out_byte <= 8'(prle_pkg::RUN_BASE - {1'b0, i_cmd.len});
                                r_out_last <= 1'b0;
                                r_out_user <= 1'b0;
                                r_state    <= S_RUN;
                            end
                            prle_pkg::CMD_LIT: begin
                                r_out_byte <= 8'({2'b00, i_cmd.cnt} + {7'd0, i_cmd.tail}
                                                 - 8'd1);
                                r_out_last <= 1'b0;
                                r_out_user <= 1'b0;
                                r_state    <= (i_cmd.cnt != '0) ? S_LIT : S_TAIL;
                            end
                            default: begin
                                r_out_byte <= prle_pkg::END_BYTE;
                                r_out_last <= 1'b1;
                                r_out_user <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_free) begin
                        r_out_byte  <= r_val;
                        r_out_last  <= r_last;
                        r_out_user  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_LIT: begin
                    if (w_free) begin
                        r_out_byte  <= r_rd_data;
                        r_out_last  <= w_lit_end && !r_tail && r_last;
                        r_out_user  <= 1'b0;
                        if (w_lit_end) begin
                            r_state <= r_tail ? S_TAIL : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_TAIL: begin
                    if (w_free) begin
                        r_out_byte  <= r_val;
                        r_out_last  <= r_last;
                        r_out_user  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_end_marker : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |-> (r_out_last && (r_out_byte == prle_pkg::END_BYTE)))
        else $error("end marker malformed");

    a_idx_in_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIT) |-> ((r_idx <= r_cnt) && (r_idx != '0)))
        else $error("literal index outside block");
`endif

endmodule

### design/packbits_run_length_encoder.sv
// ----------------------------------------------------------------------------
// packbits_run_length_encoder
// PackBits encoder: raw bytes in, encoded stream with end-of-data byte out.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries raw bytes in tdata, tlast marks the last byte of an image.
//   m_axis carries the encoded stream: tdata is the byte, tlast marks the last
//   byte caused by an input item, tuser marks the closing 128 byte.
//   a run of equal bytes leaves as header 257 minus length and the byte, up to
//   MAX_RUN bytes; differing bytes leave as header length minus one and the
//   bytes, up to MAX_LITERAL per block.
//   the front end classifies each item as it is accepted and queues up to three
//   commands; the back end sends one byte per cycle, while m_axis is ready,
//   from a four-deep queue. m_axis tvalid rises once the item's first command
//   has passed the pending registers and the queue into the output register,
//   when the queue and output register are free. an item that causes output
//   blocks the input until every command it queues, up to three, has entered
//   the queue; an item that closes a literal block blocks the input until the
//   back end has read the block out of the literal store.
//   a stalled receiver holds the output register; the queue then fills and
//   the input side stalls in turn.
//   sync reset clears control state; the literal store needs no clearing.
// ----------------------------------------------------------------------------
module packbits_run_length_encoder #(
    parameter int MAX_LITERAL = 32,
    parameter int MAX_RUN     = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] stream_end
);

    logic            w_push;
    prle_pkg::t_cmd  w_push_cmd;
    logic            w_full;
    logic            w_q_valid;
    prle_pkg::t_cmd  w_q_cmd;
    logic            w_pop;
    prle_pkg::t_wr   w_wr;
    logic            w_lit_done;
    logic            w_user;

    assign m_axis_tuser = w_user;

    prle_front #(
        .MAX_LITERAL (MAX_LITERAL),
        .MAX_RUN     (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd),
        .i_full     (w_full),
        .o_wr       (w_wr),
        .i_lit_done (w_lit_done)
    );

    prle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    prle_back #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_cmd      (w_q_cmd),
        .o_pop      (w_pop),
        .i_wr       (w_wr),
        .o_lit_done (w_lit_done),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast),
        .o_user     (w_user)
    );

endmodule
